>>> src/cssps_pkg.sv
// shared types and constants of the cubic segment path sampler
package cssps_pkg;

	// step count holds up to 32, sample index up to 31
	localparam int unsigned STEP_W = 6;
	localparam int unsigned K_W    = 5;

	// divider geometry
	localparam int unsigned DVD_W      = 18;
	localparam int unsigned REM_W      = 16;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned STEP_DIV_BITS = 18;
	localparam int unsigned H_DIV_BITS    = 16;

	// shared multiplier operand width
	localparam int unsigned MUL_W = 18;

	typedef enum logic [1:0] {
		SEEN_NONE   = 2'd0,
		SEEN_FIRST  = 2'd1,
		SEEN_SECOND = 2'd2,
		SEEN_MORE   = 2'd3
	} seen_t;

	typedef enum logic {
		CFG_SPEED_LIMIT = 1'b0,
		CFG_Y_OFFSET    = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP_LOAD,
		ST_STEP_DIV,
		ST_STEP_SAVE,
		ST_SEG_START,
		ST_MUL_SS,
		ST_MUL_N3,
		ST_MUL_KK,
		ST_MUL_NUM,
		ST_H_LOAD,
		ST_H_DIV,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_OUT_LOAD,
		ST_EMIT
	} state_t;

endpackage

>>> src/cubic_segment_path_sampler.sv
// cubic segment path sampler: waypoints in, blended path samples out
// a start waypoint is only stored, without leaving idle; any other waypoint runs a step count
// (one 18-bit restoring division, bit per cycle), a setup per segment and, per sample, a
// 16-bit h division, five passes of the shared 18x18 multiplier and the h load, output load
// and emit states; waypoints are taken one at a time and in_stall is high until the last
// sample is taken
// reset: asynchronous, clears path state and sets speed_limit 32, y_offset 0
module cubic_segment_path_sampler #(
	parameter int unsigned MAX_STEPS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   pos_x,
	input  logic signed [15:0]   pos_y,
	input  logic signed [15:0]   pos_z,
	input  logic [23:0]          color,
	input  logic                 start_of_path,
	input  logic                 end_of_path,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   out_x,
	output logic signed [15:0]   out_y,
	output logic signed [15:0]   out_z,
	output logic [23:0]          out_color,
	output logic                 last
);

	localparam int unsigned SW = cssps_pkg::STEP_W;
	localparam int unsigned KW = cssps_pkg::K_W;
	localparam int unsigned MW = cssps_pkg::MUL_W;
	localparam int unsigned DW = cssps_pkg::DVD_W;
	localparam int unsigned RW = cssps_pkg::REM_W;
	localparam int unsigned CW = cssps_pkg::CNT_W;

	cssps_pkg::state_t state_q, state_d;
	cssps_pkg::seen_t  seen_q;

	logic [7:0]          speed_limit_q;
	logic signed [15:0]  y_offset_q;

	logic signed [15:0]  prev_q [3];
	logic signed [15:0]  second_q [3];
	logic [23:0]         prev_col_q;

	logic signed [15:0]  in_p_q [3];
	logic [23:0]         in_col_q;
	logic                eop_q;

	logic                sel_q;
	logic [SW-1:0]       steps_a_q;
	logic [SW-1:0]       steps_b_q;
	logic [KW-1:0]       k_q;
	logic [15:0]         n3_q;

	logic [RW-1:0]       rem_q;
	logic [DW-1:0]       dvd_q;
	logic [15:0]         dvs_q;
	logic [DW-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;

	logic signed [2*MW-1:0] prod_q;
	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;

	logic signed [15:0]  vx_q;
	logic signed [15:0]  vy_q;

	logic signed [15:0]  seg_q0 [3];
	logic signed [15:0]  seg_q1 [3];
	logic signed [16:0]  seg_d [3];
	logic [15:0]         seg_abs [3];
	logic [15:0]         max_abs;
	logic [7:0]          sp;
	logic [DW-1:0]       step_dividend;
	logic [SW-1:0]       steps_cur;
	logic [23:0]         seg_col;
	logic                seg_end;
	logic                accept_in;
	logic                start_pt;

	logic [RW:0]         div_t;
	logic [RW:0]         div_diff;
	logic                div_ge;

	logic signed [2*MW-1:0] prod_rnd;
	logic signed [15:0]     blend_v;
	logic signed [16:0]     y_sum;
	logic signed [15:0]     y_sat;
	logic [SW-1:0]          steps_sat;

	assign accept_in = in_valid && !in_stall;
	assign start_pt  = start_of_path || (seen_q == cssps_pkg::SEEN_NONE);

	// segment geometry: sel 0 is previous -> new point, sel 1 is the closing segment
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			seg_q0[i] = sel_q ? in_p_q[i] : prev_q[i];
			seg_q1[i] = !sel_q ? in_p_q[i] :
				((seen_q == cssps_pkg::SEEN_FIRST) ? in_p_q[i] : second_q[i]);
			seg_d[i] = 17'(seg_q1[i]) - 17'(seg_q0[i]);
			seg_abs[i] = seg_d[i][16] ? 16'(-seg_d[i]) : seg_d[i][15:0];
		end
		max_abs = seg_abs[0];
		if (seg_abs[1] > max_abs) begin
			max_abs = seg_abs[1];
		end
		if (seg_abs[2] > max_abs) begin
			max_abs = seg_abs[2];
		end
	end

	assign sp            = (speed_limit_q == 8'd0) ? 8'd1 : speed_limit_q;
	assign step_dividend = DW'(max_abs) * DW'(3) + DW'(sp);
	assign steps_cur     = sel_q ? steps_b_q : steps_a_q;
	assign seg_col       = sel_q ? in_col_q : prev_col_q;
	assign seg_end       = (SW'(k_q) + SW'(1)) == steps_cur;
	assign steps_sat     = (quo_q > DW'(MAX_STEPS)) ? SW'(MAX_STEPS) : quo_q[SW-1:0];

	// one restoring division step
	assign div_t    = {rem_q, dvd_q[DW-1]};
	assign div_diff = div_t - {1'b0, dvs_q};
	assign div_ge   = (div_t >= {1'b0, dvs_q});

	// floor((d*h + 32768) / 65536), wraps into 16 bits after adding q0
	assign prod_rnd = prod_q + (2*MW)'(32768);
	assign blend_v  = prod_rnd[31:16];

	assign y_sum = 17'(vy_q) + 17'(y_offset_q);
	always_comb begin
		if (y_sum > 17'sd32767) begin
			y_sat = 16'sh7fff;
		end else if (y_sum < -17'sd32768) begin
			y_sat = -16'sh8000;
		end else begin
			y_sat = y_sum[15:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cssps_pkg::ST_IDLE: begin
				if (accept_in && !start_pt) begin
					state_d = cssps_pkg::ST_STEP_LOAD;
				end
			end
			cssps_pkg::ST_STEP_LOAD: state_d = cssps_pkg::ST_STEP_DIV;
			cssps_pkg::ST_STEP_DIV: begin
				if (cnt_q == CW'(1)) begin
					state_d = cssps_pkg::ST_STEP_SAVE;
				end
			end
			cssps_pkg::ST_STEP_SAVE: begin
				if (!sel_q && eop_q) begin
					state_d = cssps_pkg::ST_STEP_LOAD;
				end else begin
					state_d = cssps_pkg::ST_SEG_START;
				end
			end
			cssps_pkg::ST_SEG_START: begin
				if (steps_cur != '0) begin
					state_d = cssps_pkg::ST_MUL_SS;
				end else if (sel_q || steps_b_q == '0) begin
					state_d = cssps_pkg::ST_IDLE;
				end
			end
			cssps_pkg::ST_MUL_SS:  state_d = cssps_pkg::ST_MUL_N3;
			cssps_pkg::ST_MUL_N3:  state_d = cssps_pkg::ST_MUL_KK;
			cssps_pkg::ST_MUL_KK:  state_d = cssps_pkg::ST_MUL_NUM;
			cssps_pkg::ST_MUL_NUM: state_d = cssps_pkg::ST_H_LOAD;
			cssps_pkg::ST_H_LOAD:  state_d = cssps_pkg::ST_H_DIV;
			cssps_pkg::ST_H_DIV: begin
				if (cnt_q == CW'(1)) begin
					state_d = cssps_pkg::ST_MUL_X;
				end
			end
			cssps_pkg::ST_MUL_X:    state_d = cssps_pkg::ST_MUL_Y;
			cssps_pkg::ST_MUL_Y:    state_d = cssps_pkg::ST_MUL_Z;
			cssps_pkg::ST_MUL_Z:    state_d = cssps_pkg::ST_OUT_LOAD;
			cssps_pkg::ST_OUT_LOAD: state_d = cssps_pkg::ST_EMIT;
			cssps_pkg::ST_EMIT: begin
				if (!out_stall) begin
					if (!seg_end) begin
						state_d = cssps_pkg::ST_MUL_KK;
					end else if (!sel_q && steps_b_q != '0) begin
						state_d = cssps_pkg::ST_SEG_START;
					end else begin
						state_d = cssps_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = cssps_pkg::ST_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		in_stall  = (state_q != cssps_pkg::ST_IDLE);
		out_valid = (state_q == cssps_pkg::ST_EMIT);
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			cssps_pkg::ST_MUL_SS: begin
				mul_a = MW'(steps_cur);
				mul_b = MW'(steps_cur);
			end
			cssps_pkg::ST_MUL_N3: begin
				mul_a = prod_q[MW-1:0];
				mul_b = MW'(steps_cur);
			end
			cssps_pkg::ST_MUL_KK: begin
				mul_a = MW'(k_q);
				mul_b = MW'(k_q);
			end
			cssps_pkg::ST_MUL_NUM: begin
				mul_a = prod_q[MW-1:0];
				mul_b = MW'(steps_cur) * MW'(3) - (MW'(k_q) << 1);
			end
			cssps_pkg::ST_MUL_X: begin
				mul_a = MW'(seg_d[0]);
				mul_b = {2'b00, quo_q[15:0]};
			end
			cssps_pkg::ST_MUL_Y: begin
				mul_a = MW'(seg_d[1]);
				mul_b = {2'b00, quo_q[15:0]};
			end
			cssps_pkg::ST_MUL_Z: begin
				mul_a = MW'(seg_d[2]);
				mul_b = {2'b00, quo_q[15:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cssps_pkg::ST_IDLE;
			seen_q        <= cssps_pkg::SEEN_NONE;
			speed_limit_q <= 8'd32;
			y_offset_q    <= '0;
			prev_col_q    <= '0;
			eop_q         <= 1'b0;
			sel_q         <= 1'b0;
			steps_a_q     <= '0;
			steps_b_q     <= '0;
			k_q           <= '0;
			cnt_q         <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i]   <= '0;
				second_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cssps_pkg::cfg_idx_t'(cfg_index))
					cssps_pkg::CFG_SPEED_LIMIT: speed_limit_q <= cfg_data[7:0];
					cssps_pkg::CFG_Y_OFFSET:    y_offset_q    <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				cssps_pkg::ST_IDLE: begin
					if (accept_in) begin
						eop_q     <= end_of_path;
						sel_q     <= 1'b0;
						steps_b_q <= '0;
						if (start_pt) begin
							prev_q[0]  <= pos_x;
							prev_q[1]  <= pos_y;
							prev_q[2]  <= pos_z;
							prev_col_q <= color;
							seen_q     <= cssps_pkg::SEEN_FIRST;
						end
					end
				end
				cssps_pkg::ST_STEP_LOAD: cnt_q <= CW'(cssps_pkg::STEP_DIV_BITS);
				cssps_pkg::ST_STEP_DIV:  cnt_q <= cnt_q - CW'(1);
				cssps_pkg::ST_STEP_SAVE: begin
					if (sel_q) begin
						steps_b_q <= steps_sat;
					end else begin
						steps_a_q <= steps_sat;
					end
					sel_q <= !sel_q && eop_q;
				end
				cssps_pkg::ST_SEG_START: begin
					k_q <= '0;
					if (steps_cur == '0 && !sel_q && steps_b_q != '0) begin
						sel_q <= 1'b1;
					end
				end
				cssps_pkg::ST_H_LOAD: cnt_q <= CW'(cssps_pkg::H_DIV_BITS);
				cssps_pkg::ST_H_DIV:  cnt_q <= cnt_q - CW'(1);
				cssps_pkg::ST_EMIT: begin
					if (!out_stall) begin
						if (!seg_end) begin
							k_q <= k_q + KW'(1);
						end else if (!sel_q && steps_b_q != '0) begin
							sel_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase

			// path state moves on once the waypoint's last transaction is out
			if (in_stall && state_d == cssps_pkg::ST_IDLE) begin
				prev_q     <= in_p_q;
				prev_col_q <= in_col_q;
				if (eop_q) begin
					seen_q <= cssps_pkg::SEEN_NONE;
				end else if (seen_q == cssps_pkg::SEEN_FIRST) begin
					seen_q <= cssps_pkg::SEEN_SECOND;
				end else if (seen_q == cssps_pkg::SEEN_SECOND) begin
					seen_q <= cssps_pkg::SEEN_MORE;
				end
				if (seen_q == cssps_pkg::SEEN_FIRST) begin
					second_q <= in_p_q;
				end
			end
		end
	end

	// datapath: shared multiplier, shared divider, sample assembly
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (accept_in) begin
			in_p_q[0] <= pos_x;
			in_p_q[1] <= pos_y;
			in_p_q[2] <= pos_z;
			in_col_q  <= color;
		end

		unique case (state_q)
			cssps_pkg::ST_STEP_LOAD: begin
				rem_q <= '0;
				dvd_q <= step_dividend;
				dvs_q <= {7'b0, sp, 1'b0};
				quo_q <= '0;
			end
			cssps_pkg::ST_MUL_KK: begin
				if (k_q == '0) begin
					n3_q <= prod_q[15:0];
				end
			end
			cssps_pkg::ST_H_LOAD: begin
				// remainder starts at num, then the bits of n3/2 shift in
				rem_q <= prod_q[RW-1:0];
				dvd_q <= {1'b0, n3_q[15:1], 2'b00};
				dvs_q <= n3_q;
				quo_q <= '0;
			end
			cssps_pkg::ST_STEP_DIV, cssps_pkg::ST_H_DIV: begin
				rem_q <= div_ge ? div_diff[RW-1:0] : div_t[RW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				quo_q <= {quo_q[DW-2:0], div_ge};
			end
			cssps_pkg::ST_MUL_Y: vx_q <= seg_q0[0] + blend_v;
			cssps_pkg::ST_MUL_Z: vy_q <= seg_q0[1] + blend_v;
			cssps_pkg::ST_OUT_LOAD: begin
				out_x     <= vx_q;
				out_y     <= y_sat;
				out_z     <= seg_q0[2] + blend_v;
				out_color <= seg_col;
				last      <= seg_end && (sel_q || steps_b_q == '0);
			end
			default: ;
		endcase
	end

	// no new waypoint while a sample is offered
	a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a sample is pending");

	// the final sample of a waypoint ends its work
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid && !in_stall)
		else $error("activity after the last sample");

	// sample index stays inside the segment
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (SW'(k_q) < steps_cur))
		else $error("sample index beyond step count");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cssps_pkg::ST_STEP_DIV || state_q == cssps_pkg::ST_H_DIV)
			|-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

endmodule

>>> sim/cubic_segment_path_sampler_test.sv
// testbench of the cubic segment path sampler: random and directed waypoints against a predictor
`timescale 1ns / 1ps

module cubic_segment_path_sampler_test;

	localparam int MAX_STEPS      = 32;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 80;

	typedef int point_t [3];

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [23:0]        color;
		logic               last;
	} sample_t;

	class path_scoreboard;
		logic [7:0]         speed_limit;
		logic signed [15:0] y_offset;
		point_t             prev_point;
		point_t             second_point;
		logic [23:0]        prev_color;
		cssps_pkg::seen_t   seen;
		sample_t            expected_samples[$];
		int                 mismatches;
		int                 samples_checked;
		int                 waypoints_noted;

		function new();
			speed_limit     = 8'd32;
			y_offset        = 16'sd0;
			prev_point      = '{0, 0, 0};
			second_point    = '{0, 0, 0};
			prev_color      = 24'd0;
			seen            = cssps_pkg::SEEN_NONE;
			mismatches      = 0;
			samples_checked = 0;
			waypoints_noted = 0;
		endfunction

		function void set_registers(logic [7:0] speed, logic signed [15:0] offset);
			speed_limit = speed;
			y_offset    = offset;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		// d * h16 / 65536, rounded to nearest with ties upward
		function int blend_offset(int d, longint h16);
			longint p;
			p = longint'(d) * h16 + 32768;
			if (p >= 0)
				return int'(p / 65536);
			return int'(-((-p + 65535) / 65536));
		endfunction

		function void add_segment(point_t from_pt, point_t to_pt, logic [23:0] col);
			int      d [3];
			int      v [3];
			int      mag;
			int      a;
			int      sp;
			int      steps;
			int      k;
			int      y;
			longint  cube;
			longint  num;
			longint  h16;
			sample_t s;
			mag = 0;
			sp  = (speed_limit == 8'd0) ? 1 : int'(speed_limit);
			for (int i = 0; i < 3; i++) begin
				d[i] = to_pt[i] - from_pt[i];
				a    = (d[i] < 0) ? -d[i] : d[i];
				if (a > mag)
					mag = a;
			end
			steps = (3 * mag + sp) / (2 * sp);
			if (steps > MAX_STEPS)
				steps = MAX_STEPS;
			for (k = 0; k < steps; k++) begin
				cube = longint'(steps) * steps * steps;
				num  = 3 * longint'(k) * k * steps - 2 * longint'(k) * k * k;
				h16  = (num * 65536 + cube / 2) / cube;
				for (int i = 0; i < 3; i++)
					v[i] = from_pt[i] + blend_offset(d[i], h16);
				y = v[1] + int'(y_offset);
				if (y > 32767)
					y = 32767;
				if (y < -32768)
					y = -32768;
				s.x     = 16'(v[0]);
				s.y     = 16'(y);
				s.z     = 16'(v[2]);
				s.color = col;
				s.last  = 1'b0;
				expected_samples = {expected_samples, s};
			end
		endfunction

		function void note_waypoint(logic signed [15:0] x, logic signed [15:0] y,
				logic signed [15:0] z, logic [23:0] col, logic sop, logic eop);
			point_t  p;
			int      queued;
			sample_t tail;
			waypoints_noted++;
			p = '{int'(x), int'(y), int'(z)};
			if (sop || seen == cssps_pkg::SEEN_NONE) begin
				prev_point = p;
				prev_color = col;
				seen       = cssps_pkg::SEEN_FIRST;
				return;
			end
			queued = expected_samples.size();
			add_segment(prev_point, p, prev_color);
			if (seen == cssps_pkg::SEEN_FIRST) begin
				second_point = p;
				seen         = cssps_pkg::SEEN_SECOND;
			end else if (seen == cssps_pkg::SEEN_SECOND) begin
				seen = cssps_pkg::SEEN_MORE;
			end
			// closing segment runs back to the second waypoint
			if (eop) begin
				add_segment(p, second_point, col);
				seen = cssps_pkg::SEEN_NONE;
			end
			prev_point = p;
			prev_color = col;
			if (expected_samples.size() > queued) begin
				tail      = expected_samples.pop_back();
				tail.last = 1'b1;
				expected_samples = {expected_samples, tail};
			end
		endfunction

		function void check_sample(logic signed [15:0] x, logic signed [15:0] y,
				logic signed [15:0] z, logic [23:0] col, logic lst);
			sample_t want;
			if (expected_samples.size() == 0) begin
				$error("sample with nothing expected: x=%0d y=%0d z=%0d", x, y, z);
				mismatches++;
				return;
			end
			want = expected_samples.pop_front();
			samples_checked++;
			if (x !== want.x) begin
				$error("out_x expected %0d got %0d", want.x, x);
				mismatches++;
			end
			if (y !== want.y) begin
				$error("out_y expected %0d got %0d", want.y, y);
				mismatches++;
			end
			if (z !== want.z) begin
				$error("out_z expected %0d got %0d", want.z, z);
				mismatches++;
			end
			if (col !== want.color) begin
				$error("out_color expected %06h got %06h", want.color, col);
				mismatches++;
			end
			if (lst !== want.last) begin
				$error("last expected %0b got %0b", want.last, lst);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = 1'b0;
	logic [15:0]        cfg_data = 16'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] pos_x = 16'sd0;
	logic signed [15:0] pos_y = 16'sd0;
	logic signed [15:0] pos_z = 16'sd0;
	logic [23:0]        color = 24'd0;
	logic               start_of_path = 1'b0;
	logic               end_of_path = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic [23:0]        out_color;
	logic               last;

	path_scoreboard     sb = new();
	int                 send_idle_pct = 8;
	int                 recv_idle_pct = 64;
	logic               hold_req = 1'b0;
	logic               hold_ack = 1'b0;
	int                 hold_left = 0;
	int                 quiet_cycles = 0;
	int                 settings_used = 1;
	logic signed [15:0] walk [3];

	cubic_segment_path_sampler #(.MAX_STEPS(MAX_STEPS)) dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_sample(out_x, out_y, out_z, out_color, last);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_waypoint(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [23:0] col, logic sop, logic eop);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		pos_x         <= x;
		pos_y         <= y;
		pos_z         <= z;
		color         <= col;
		start_of_path <= sop;
		end_of_path   <= eop;
		do @(posedge clk); while (in_stall);
		sb.note_waypoint(x, y, z, col, sop, eop);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// only while idle: drain, let a sampleless waypoint finish, then write
	task automatic write_registers(logic [7:0] speed, logic signed [15:0] offset);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= cssps_pkg::CFG_SPEED_LIMIT;
		cfg_data  <= {8'h00, speed};
		@(posedge clk);
		cfg_index <= cssps_pkg::CFG_Y_OFFSET;
		cfg_data  <= offset;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_registers(speed, offset);
		settings_used++;
	endtask

	function automatic logic signed [15:0] wander(int from);
		int to;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: to = from + int'($urandom_range(128)) - 64;
			5, 6, 7:       to = from + int'($urandom_range(4000)) - 2000;
			8:             to = int'($signed(16'($urandom)));
			default:       to = from;
		endcase
		if (to > 32767)
			to = 32767;
		if (to < -32768)
			to = -32768;
		return 16'(to);
	endfunction

	// mostly well-formed paths with random geometry, some raw noise
	task automatic run_random_paths(int n_items);
		int   sent;
		int   len;
		logic eop;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				send_waypoint(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
					1'($urandom), 1'($urandom));
				sent++;
			end else begin
				for (int i = 0; i < 3; i++)
					walk[i] = 16'($urandom);
				send_waypoint(walk[0], walk[1], walk[2], 24'($urandom), 1'b1, 1'($urandom));
				sent++;
				len = $urandom_range(6, 1);
				for (int j = 0; j < len; j++) begin
					for (int i = 0; i < 3; i++)
						walk[i] = wander(walk[i]);
					eop = (j == len - 1) && ($urandom_range(99) < 80);
					send_waypoint(walk[0], walk[1], walk[2], 24'($urandom), 1'b0, eop);
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values: step rounding, zero delta, path control
		send_waypoint(16'sd0, 16'sd0, 16'sd0, 24'h000000, 1'b0, 1'b0);
		send_waypoint(16'sd11, 16'sd0, 16'sd0, 24'h123456, 1'b0, 1'b0);
		send_waypoint(16'sd21, 16'sd0, 16'sd0, 24'h00ff00, 1'b0, 1'b0);
		send_waypoint(16'sd21, -16'sd600, 16'sd0, 24'h0000ff, 1'b0, 1'b0);
		send_waypoint(16'sd21, -16'sd600, 16'sd0, 24'h808080, 1'b0, 1'b0);
		send_waypoint(-16'sd32768, 16'sd32767, -16'sd32768, 24'hffffff, 1'b0, 1'b0);
		send_waypoint(16'sd32767, -16'sd32768, 16'sd32767, 24'h000000, 1'b0, 1'b1);
		send_waypoint(16'sd5, 16'sd5, 16'sd5, 24'habcdef, 1'b1, 1'b1);
		send_waypoint(-16'sd5, 16'sd40, 16'sd5, 24'h654321, 1'b0, 1'b1);
		send_waypoint(16'sd100, 16'sd100, 16'sd100, 24'h111111, 1'b0, 1'b0);
		send_waypoint(-16'sd100, 16'sd300, -16'sd20, 24'h222222, 1'b0, 1'b1);

		// slowest speed, y sum saturating high
		write_registers(8'd1, 16'sh7fff);
		send_waypoint(16'sd0, 16'sd32000, 16'sd0, 24'hff0000, 1'b1, 1'b0);
		send_waypoint(16'sd40, 16'sd32767, -16'sd40, 24'h00ffff, 1'b0, 1'b0);
		send_waypoint(-16'sd32768, -16'sd32768, 16'sd32767, 24'hf0f0f0, 1'b0, 1'b1);

		// fastest speed, y sum saturating low
		write_registers(8'd255, -16'sd32768);
		send_waypoint(16'sd32767, 16'sd32767, 16'sd32767, 24'hffffff, 1'b1, 1'b0);
		send_waypoint(-16'sd32768, -16'sd32768, -16'sd32768, 24'h000000, 1'b0, 1'b0);
		send_waypoint(-16'sd32768, -16'sd32000, -16'sd32768, 24'h0f0f0f, 1'b0, 1'b1);

		// zero speed behaves as one
		write_registers(8'd0, 16'sd1234);
		send_waypoint(16'sd0, 16'sd0, 16'sd0, 24'h010203, 1'b1, 1'b0);
		send_waypoint(16'sd1, 16'sd0, 16'sd0, 24'h040506, 1'b0, 1'b0);
		send_waypoint(16'sd1, 16'sd0, 16'sd0, 24'h070809, 1'b0, 1'b0);
		send_waypoint(-16'sd2, 16'sd3, 16'sd1, 24'h0a0b0c, 1'b0, 1'b1);

		write_registers(8'($urandom_range(255, 1)), 16'($urandom));
		run_random_paths(60);

		// receiver mostly ready, sender mostly idle; one full drain midway
		send_idle_pct = 64;
		recv_idle_pct <= 8;
		write_registers(8'($urandom_range(255, 1)), 16'($urandom));
		run_random_paths(30);
		wait_drain();
		run_random_paths(30);

		// no idling; long receiver hold-off so the block backs up its input
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		write_registers(8'($urandom_range(64, 1)), 16'($urandom));
		hold_req <= ~hold_req;
		run_random_paths(60);

		wait_drain();
		repeat (200) @(posedge clk);
		$display("%0d waypoints over %0d register settings, %0d samples checked",
			sb.waypoints_noted, settings_used, sb.samples_checked);
		$display("%0d mismatches", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> cubic_segment_path_sampler.f
src/cssps_pkg.sv
src/cubic_segment_path_sampler.sv
sim/cubic_segment_path_sampler_test.sv
